// ===== hdl/rlt_pkg.sv =====
// ---------------------------------------------------------------------------
// Rule language tokenizer package
// Shared types, token kinds and widths for the tokenizer block.
// ---------------------------------------------------------------------------
package rlt_pkg;

  localparam int PosWidth = 24;
  localparam logic [PosWidth-1:0] LcMax = {PosWidth{1'b1}};

  typedef enum logic [4:0] {
    K_EOF = 5'd0, K_INT = 5'd1, K_IDENT = 5'd2, K_WILD = 5'd3, K_NOT = 5'd4,
    K_STRING = 5'd5, K_INVALID = 5'd6, K_DOT = 5'd7, K_PRED = 5'd8,
    K_CLEAR = 5'd9, K_COMMA = 5'd10, K_LPAREN = 5'd11, K_RPAREN = 5'd12,
    K_COLON = 5'd13, K_ARROW = 5'd14, K_EQ = 5'd15, K_NE = 5'd16,
    K_LT = 5'd17, K_LE = 5'd18, K_GT = 5'd19, K_GE = 5'd20, K_CHAR = 5'd21
  } tok_kind_t;

  typedef enum logic [10:0] {
    M_IDLE    = 11'b00000000001,
    M_COMMENT = 11'b00000000010,
    M_NUMBER  = 11'b00000000100,
    M_IDENT   = 11'b00000001000,
    M_STRING  = 11'b00000010000,
    M_ESC     = 11'b00000100000,
    M_DOT     = 11'b00001000000,
    M_COLON   = 11'b00010000000,
    M_BANG    = 11'b00100000000,
    M_LT      = 11'b01000000000,
    M_GT      = 11'b10000000000
  } mode_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [63:0] number_value;
    logic [23:0] line_number;
    logic [23:0] column_number;
    logic [7:0]  char_value;
    logic        last;
  } out_item_t;

  function automatic logic [7:0] kw_char(input logic pred, input logic [3:0] idx);
    logic [7:0] c;
    begin
      c = 8'h00;
      if (pred) begin
        case (idx)
          4'd0: c = "p";
          4'd1: c = "r";
          4'd2: c = "e";
          4'd3: c = "d";
          default: c = 8'h00;
        endcase
      end else begin
        case (idx)
          4'd0: c = "c";
          4'd1: c = "l";
          4'd2: c = "e";
          4'd3: c = "a";
          4'd4: c = "r";
          4'd5: c = "_";
          4'd6: c = "d";
          4'd7: c = "e";
          4'd8: c = "r";
          4'd9: c = "i";
          4'd10: c = "v";
          4'd11: c = "e";
          4'd12: c = "d";
          default: c = 8'h00;
        endcase
      end
      return c;
    end
  endfunction

endpackage

// ===== hdl/rule_language_tokenizer_top.sv =====
// ---------------------------------------------------------------------------
// Rule language tokenizer
// Streaming tokenizer, one source byte per transaction.
// ---------------------------------------------------------------------------
// The block takes one byte or end mark per cycle while there is room and gives
// one result per cycle while the output is ready from an eight-entry queue;
// each input yields zero to three results, so the sustained input rate is set
// by the single output port whenever bytes cause more than one result (closing tokens).
module rule_language_tokenizer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rlt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rlt_pkg::out_item_t out_data
);

  logic room, push;
  logic [1:0] cnt;
  rlt_pkg::out_item_t r0, r1, r2;

  rlt_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_room(room), .q_push(push), .q_count(cnt),
    .q_res0(r0), .q_res1(r1), .q_res2(r2)
  );

  rlt_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_count(cnt), .push0(r0),
    .push1(r1), .push2(r2), .room(room), .out_valid(out_valid),
    .out_ready(out_ready), .out_item(out_data)
  );

endmodule

// ===== hdl/rlt_front.sv =====
// ---------------------------------------------------------------------------
// Tokenizer front end
// Accepts bytes, runs the lexer state, and writes up to three results into
// the result queue per accepted transaction.
// ---------------------------------------------------------------------------
module rlt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rlt_pkg::in_item_t   in_data,
  input  logic                q_room,
  output logic                q_push,
  output logic [1:0]          q_count,
  output rlt_pkg::out_item_t  q_res0,
  output rlt_pkg::out_item_t  q_res1,
  output rlt_pkg::out_item_t  q_res2
);

  rlt_pkg::mode_t mode, mode_next;
  logic [31:0] position, position_next;
  logic [23:0] cur_line, cur_line_next;
  logic [23:0] cur_column, cur_column_next;
  logic [31:0] token_start, token_start_next;
  logic [63:0] number_acc, number_acc_next;
  logic [3:0]  kw_idx, kw_idx_next;
  logic [1:0]  kw_cand, kw_cand_next;
  logic [1:0]  not_prog, not_prog_next;
  logic        lone_us, lone_us_next;

  rlt_pkg::out_item_t res [3];
  logic [1:0] cnt;

  assign in_ready = q_room;
  assign q_push = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= rlt_pkg::M_IDLE;
      position <= '0;
      cur_line <= 24'd1;
      cur_column <= 24'd1;
      token_start <= '0;
      number_acc <= '0;
      kw_idx <= '0;
      kw_cand <= 2'd3;
      not_prog <= '0;
      lone_us <= 1'b0;
    end else if (q_push) begin
      mode <= mode_next;
      position <= position_next;
      cur_line <= cur_line_next;
      cur_column <= cur_column_next;
      token_start <= token_start_next;
      number_acc <= number_acc_next;
      kw_idx <= kw_idx_next;
      kw_cand <= kw_cand_next;
      not_prog <= not_prog_next;
      lone_us <= lone_us_next;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic done;
    logic is_dig, is_ids, is_idb;
    logic [31:0] len;
    logic [7:0] kc;
    logic [3:0] klen;
    logic [23:0] col;
    logic [63:0] prod;
    rlt_pkg::tok_kind_t ik;
    b = in_data.data_byte;
    mode_next = mode;
    position_next = position;
    cur_line_next = cur_line;
    cur_column_next = cur_column;
    token_start_next = token_start;
    number_acc_next = number_acc;
    kw_idx_next = kw_idx;
    kw_cand_next = kw_cand;
    not_prog_next = not_prog;
    lone_us_next = lone_us;
    cnt = 2'd0;
    done = 1'b0;
    kc = '0;
    klen = '0;
    col = '0;
    ik = rlt_pkg::K_IDENT;
    prod = '0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '0;
    end
    is_dig = (b >= "0") && (b <= "9");
    is_ids = ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z")) || (b == "_");
    is_idb = is_ids || is_dig;

    if (in_data.kind) begin
      len = position - token_start;
      ik = rlt_pkg::K_IDENT;
      if (lone_us && len == 32'd1) ik = rlt_pkg::K_WILD;
      else if (not_prog == 2'd3 && len == 32'd3) ik = rlt_pkg::K_NOT;
      case (mode)
        rlt_pkg::M_NUMBER: begin
          res[0] = '{rlt_pkg::K_INT, token_start, len, number_acc, cur_line,
                     cur_column, 8'd0, 1'b0};
          cnt = 2'd1;
        end
        rlt_pkg::M_IDENT: begin
          res[0] = '{ik, token_start, len, 64'd0, cur_line, cur_column, 8'd0, 1'b0};
          cnt = 2'd1;
        end
        rlt_pkg::M_STRING, rlt_pkg::M_ESC: begin
          res[0] = '{rlt_pkg::K_INVALID, token_start, len, 64'd0, cur_line,
                     cur_column, 8'd0, 1'b0};
          cnt = 2'd1;
        end
        rlt_pkg::M_DOT: begin
          col = cur_column;
          if (col < rlt_pkg::LcMax) col = (col > {20'd0, kw_idx}) ? col - {20'd0, kw_idx} : 24'd1;
          res[0] = '{rlt_pkg::K_DOT, token_start, 32'd1, 64'd0, cur_line, col, 8'd0, 1'b0};
          cnt = 2'd1;
          if (kw_idx != 4'd0) begin
            // Matched letters never spell "not" nor a lone underscore.
            res[1] = '{rlt_pkg::K_IDENT, token_start + 32'd1, position - token_start - 32'd1,
                       64'd0, cur_line, cur_column, 8'd0, 1'b0};
            cnt = 2'd2;
          end
        end
        rlt_pkg::M_COLON: begin
          res[0] = '{rlt_pkg::K_COLON, token_start, 32'd1, 64'd0, cur_line,
                     cur_column, 8'd0, 1'b0};
          cnt = 2'd1;
        end
        rlt_pkg::M_BANG: begin
          res[0] = '{rlt_pkg::K_INVALID, token_start, 32'd1, 64'd0, cur_line,
                     cur_column, 8'd0, 1'b0};
          cnt = 2'd1;
        end
        rlt_pkg::M_LT: begin
          res[0] = '{rlt_pkg::K_LT, token_start, 32'd1, 64'd0, cur_line,
                     cur_column, 8'd0, 1'b0};
          cnt = 2'd1;
        end
        rlt_pkg::M_GT: begin
          res[0] = '{rlt_pkg::K_GT, token_start, 32'd1, 64'd0, cur_line,
                     cur_column, 8'd0, 1'b0};
          cnt = 2'd1;
        end
        default: ;
      endcase
      res[cnt] = '{rlt_pkg::K_EOF, position, 32'd0, 64'd0, cur_line, cur_column,
                   8'd0, 1'b0};
      cnt = cnt + 2'd1;
      mode_next = rlt_pkg::M_IDLE;
      position_next = '0;
      cur_line_next = 24'd1;
      cur_column_next = 24'd1;
      token_start_next = '0;
      number_acc_next = '0;
      kw_idx_next = '0;
      kw_cand_next = 2'd3;
      not_prog_next = '0;
      lone_us_next = 1'b0;
    end else begin
      // A byte re-offered after closing a token is handled in idle, or in the identifier state after a failed keyword.
      for (int pass = 0; pass < 4; pass++) begin
        if (!done) begin
          len = position_next - token_start_next;
          case (mode_next)
            rlt_pkg::M_COMMENT: begin
              if (b == 8'd10) begin
                mode_next = rlt_pkg::M_IDLE;
              end else begin
                done = 1'b1;
              end
            end
            rlt_pkg::M_NUMBER: begin
              if (is_dig) begin
                prod = {number_acc_next[60:0], 3'b000} + {number_acc_next[62:0], 1'b0};
                number_acc_next = prod + {56'd0, b - 8'h30};
                done = 1'b1;
              end else begin
                res[cnt] = '{rlt_pkg::K_INT, token_start_next, len, number_acc_next,
                             cur_line_next, cur_column_next, 8'd0, 1'b0};
                cnt = cnt + 2'd1;
                mode_next = rlt_pkg::M_IDLE;
              end
            end
            rlt_pkg::M_IDENT: begin
              if (is_idb) begin
                if (len < 32'd3 && {30'd0, not_prog_next} == len &&
                    ((len == 32'd0 && b == "n") || (len == 32'd1 && b == "o") ||
                     (len == 32'd2 && b == "t")))
                  not_prog_next = not_prog_next + 2'd1;
                lone_us_next = 1'b0;
                done = 1'b1;
              end else begin
                ik = rlt_pkg::K_IDENT;
                if (lone_us_next && len == 32'd1) ik = rlt_pkg::K_WILD;
                else if (not_prog_next == 2'd3 && len == 32'd3) ik = rlt_pkg::K_NOT;
                res[cnt] = '{ik, token_start_next, len, 64'd0, cur_line_next,
                             cur_column_next, 8'd0, 1'b0};
                cnt = cnt + 2'd1;
                mode_next = rlt_pkg::M_IDLE;
              end
            end
            rlt_pkg::M_STRING: begin
              done = 1'b1;
              if (b == "\"") begin
                res[cnt] = '{rlt_pkg::K_STRING, token_start_next, len + 32'd1, 64'd0,
                             24'd0, 24'd0, 8'd0, 1'b0};
                cnt = cnt + 2'd1;
                mode_next = rlt_pkg::M_IDLE;
              end else if (b == 8'h5c) begin
                mode_next = rlt_pkg::M_ESC;
              end else begin
                res[cnt] = '{rlt_pkg::K_CHAR, token_start_next, 32'd0, 64'd0, 24'd0,
                             24'd0, b, 1'b0};
                cnt = cnt + 2'd1;
              end
            end
            rlt_pkg::M_ESC: begin
              done = 1'b1;
              res[cnt] = '{rlt_pkg::K_CHAR, token_start_next, 32'd0, 64'd0, 24'd0, 24'd0,
                           (b == "n") ? 8'd10 : ((b == "t") ? 8'd9 : b), 1'b0};
              cnt = cnt + 2'd1;
              mode_next = rlt_pkg::M_STRING;
            end
            rlt_pkg::M_DOT: begin
              if (kw_cand_next == 2'd3) begin
                if (b == "p") kw_cand_next = 2'd1;
                else if (b == "c") kw_cand_next = 2'd2;
              end
              klen = (kw_cand_next == 2'd1) ? 4'd4 : 4'd13;
              kc = rlt_pkg::kw_char(kw_cand_next == 2'd1, kw_idx_next);
              if (kw_cand_next == 2'd3 || kw_idx_next >= klen || b != kc) begin
                col = cur_column_next;
                if (col < rlt_pkg::LcMax)
                  col = (col > {20'd0, kw_idx_next}) ? col - {20'd0, kw_idx_next} : 24'd1;
                res[cnt] = '{rlt_pkg::K_DOT, token_start_next, 32'd1, 64'd0,
                             cur_line_next, col, 8'd0, 1'b0};
                cnt = cnt + 2'd1;
                if (kw_idx_next != 4'd0) begin
                  token_start_next = token_start_next + 32'd1;
                  not_prog_next = '0;
                  lone_us_next = 1'b0;
                  mode_next = rlt_pkg::M_IDENT;
                end else begin
                  mode_next = rlt_pkg::M_IDLE;
                end
              end else begin
                done = 1'b1;
                kw_idx_next = kw_idx_next + 4'd1;
                if (kw_idx_next == klen) begin
                  res[cnt] = '{(kw_cand_next == 2'd1) ? rlt_pkg::K_PRED : rlt_pkg::K_CLEAR,
                               token_start_next, {28'd0, klen} + 32'd1, 64'd0, 24'd0,
                               24'd0, 8'd0, 1'b0};
                  cnt = cnt + 2'd1;
                  mode_next = rlt_pkg::M_IDLE;
                end
              end
            end
            rlt_pkg::M_COLON, rlt_pkg::M_BANG, rlt_pkg::M_LT, rlt_pkg::M_GT: begin
              if ((mode_next == rlt_pkg::M_COLON && b == "-") ||
                  (mode_next != rlt_pkg::M_COLON && b == "=") ||
                  (mode_next == rlt_pkg::M_LT && b == ">")) begin
                done = 1'b1;
                case (mode_next)
                  rlt_pkg::M_COLON: ik = rlt_pkg::K_ARROW;
                  rlt_pkg::M_BANG: ik = rlt_pkg::K_NE;
                  rlt_pkg::M_LT: ik = (b == "=") ? rlt_pkg::K_LE : rlt_pkg::K_NE;
                  default: ik = rlt_pkg::K_GE;
                endcase
                res[cnt] = '{ik, token_start_next, 32'd2, 64'd0, 24'd0, 24'd0, 8'd0, 1'b0};
              end else begin
                case (mode_next)
                  rlt_pkg::M_COLON: ik = rlt_pkg::K_COLON;
                  rlt_pkg::M_BANG: ik = rlt_pkg::K_INVALID;
                  rlt_pkg::M_LT: ik = rlt_pkg::K_LT;
                  default: ik = rlt_pkg::K_GT;
                endcase
                res[cnt] = '{ik, token_start_next, 32'd1, 64'd0, cur_line_next,
                             cur_column_next, 8'd0, 1'b0};
              end
              cnt = cnt + 2'd1;
              mode_next = rlt_pkg::M_IDLE;
            end
            default: begin
              done = 1'b1;
              if (b == " " || b == 8'd9 || b == 8'd13 || b == 8'd10) begin
              end else if (b == "%") begin
                mode_next = rlt_pkg::M_COMMENT;
              end else begin
                token_start_next = position_next;
                if (b == ".") begin
                  kw_idx_next = '0;
                  kw_cand_next = 2'd3;
                  mode_next = rlt_pkg::M_DOT;
                end else if (b == "," || b == "(" || b == ")" || b == "=") begin
                  case (b)
                    ",": ik = rlt_pkg::K_COMMA;
                    "(": ik = rlt_pkg::K_LPAREN;
                    ")": ik = rlt_pkg::K_RPAREN;
                    default: ik = rlt_pkg::K_EQ;
                  endcase
                  res[cnt] = '{ik, position_next, 32'd1, 64'd0, 24'd0, 24'd0, 8'd0, 1'b0};
                  cnt = cnt + 2'd1;
                end else if (b == ":") mode_next = rlt_pkg::M_COLON;
                else if (b == "!") mode_next = rlt_pkg::M_BANG;
                else if (b == "<") mode_next = rlt_pkg::M_LT;
                else if (b == ">") mode_next = rlt_pkg::M_GT;
                else if (b == "\"") mode_next = rlt_pkg::M_STRING;
                else if (is_dig) begin
                  number_acc_next = {56'd0, b - 8'h30};
                  mode_next = rlt_pkg::M_NUMBER;
                end else if (is_ids) begin
                  not_prog_next = (b == "n") ? 2'd1 : 2'd0;
                  lone_us_next = (b == "_");
                  mode_next = rlt_pkg::M_IDENT;
                end else begin
                  res[cnt] = '{rlt_pkg::K_INVALID, position_next, 32'd1, 64'd0, 24'd0,
                               24'd0, 8'd0, 1'b0};
                  cnt = cnt + 2'd1;
                end
              end
            end
          endcase
        end
      end
      // The consumed byte advances the position; results made after it
      // carry the advanced line and column.
      position_next = position_next + 32'd1;
      if (b == 8'd10) begin
        if (cur_line_next < rlt_pkg::LcMax) cur_line_next = cur_line_next + 24'd1;
        cur_column_next = 24'd1;
      end else if (cur_column_next < rlt_pkg::LcMax) begin
        cur_column_next = cur_column_next + 24'd1;
      end
      for (int k = 0; k < 3; k++) begin
        if (res[k].line_number == 24'd0 && k < cnt) begin
          res[k].line_number = cur_line_next;
          res[k].column_number = cur_column_next;
        end
      end
    end
    if (cnt != 2'd0) res[cnt - 2'd1].last = 1'b1;
  end

  assign q_count = cnt;
  assign q_res0 = res[0];
  assign q_res1 = res[1];
  assign q_res2 = res[2];

endmodule

// ===== hdl/rlt_queue.sv =====
// ---------------------------------------------------------------------------
// Tokenizer result queue
// Holds result items between front end and output port, up to eight deep,
// taking up to three per cycle while room is high and giving one per ready cycle.
// ---------------------------------------------------------------------------
module rlt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [1:0]         push_count,
  input  rlt_pkg::out_item_t push0,
  input  rlt_pkg::out_item_t push1,
  input  rlt_pkg::out_item_t push2,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output rlt_pkg::out_item_t out_item
);

  rlt_pkg::out_item_t mem [8];
  logic [2:0] rd_ptr;
  logic [2:0] wr_ptr;
  logic [3:0] fill;
  logic pop;
  logic [1:0] n;

  assign n = push ? push_count : 2'd0;
  assign pop = out_valid && out_ready;
  assign out_valid = (fill != 4'd0);
  assign out_item = mem[rd_ptr];
  assign room = (fill <= 4'd5);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill <= '0;
    end else begin
      rd_ptr <= rd_ptr + {2'd0, pop};
      wr_ptr <= wr_ptr + {1'b0, n};
      fill <= fill + {2'd0, n} - {3'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (n >= 2'd1) mem[wr_ptr] <= push0;
    if (n >= 2'd2) mem[wr_ptr + 3'd1] <= push1;
    if (n == 2'd3) mem[wr_ptr + 3'd2] <= push2;
  end

endmodule

// ===== hdl/rlt_checker.sv =====
// ---------------------------------------------------------------------------
// Tokenizer port checker
// Checks port behavior of the tokenizer over time.
// ---------------------------------------------------------------------------
module rlt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input rlt_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input rlt_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.kind |=> out_valid)
    else $error("end mark gave no result");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.token_kind <= rlt_pkg::K_CHAR)
    else $error("token kind out of range");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_kind == rlt_pkg::K_EOF |-> out_data.last)
    else $error("end token not last");

endmodule

bind rule_language_tokenizer_top rlt_checker u_rlt_checker (.*);

// ===== tb/sv/rule_language_tokenizer_top_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Rule language tokenizer testbench
// Streams directed and random source text through the tokenizer, predicts
// every token and string character, and compares each output transaction
// field by field while both sides idle and stall at random.
// ---------------------------------------------------------------------------
module rule_language_tokenizer_top_test;

  localparam int StallLimit = 5000;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  rlt_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  rlt_pkg::out_item_t out_data;

  rule_language_tokenizer_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Tokenizer state as predicted.
  rlt_pkg::mode_t lx_mode;
  logic [31:0]    lx_pos;
  logic [31:0]    lx_start;
  logic [23:0]    lx_line;
  logic [23:0]    lx_col;
  logic [63:0]    lx_acc;
  int unsigned    lx_kw_idx;
  int unsigned    lx_cand;
  int unsigned    lx_not_prog;
  bit             lx_lone;

  rlt_pkg::out_item_t step_tokens[$];
  rlt_pkg::out_item_t token_q[$];
  int        errors;
  bit        quiet;
  int        rx_hold;
  int        rx_wait;
  int        idle_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void lex_reset();
    lx_mode = rlt_pkg::M_IDLE;
    lx_pos = '0;
    lx_line = 24'd1;
    lx_col = 24'd1;
    lx_start = '0;
    lx_acc = '0;
    lx_kw_idx = 0;
    lx_cand = 3;
    lx_not_prog = 0;
    lx_lone = 1'b0;
  endfunction

  function automatic void put_token(rlt_pkg::tok_kind_t k, logic [31:0] st,
                                    logic [31:0] len, logic [63:0] val,
                                    logic [23:0] col, logic [7:0] ch);
    rlt_pkg::out_item_t t;
    if (step_tokens.size() < 3) begin
      t.token_kind = k;
      t.start_offset = st;
      t.token_length = len;
      t.number_value = val;
      t.line_number = lx_line;
      t.column_number = col;
      t.char_value = ch;
      t.last = 1'b0;
      step_tokens.push_back(t);
    end
  endfunction

  function automatic void put_simple(rlt_pkg::tok_kind_t k, logic [31:0] len);
    put_token(k, lx_start, len, 64'd0, lx_col, 8'd0);
  endfunction

  function automatic logic [31:0] span();
    return lx_pos - lx_start;
  endfunction

  function automatic void advance(logic [7:0] b);
    lx_pos = lx_pos + 32'd1;
    if (b == 8'h0a) begin
      if (lx_line < rlt_pkg::LcMax) lx_line = lx_line + 24'd1;
      lx_col = 24'd1;
    end else if (lx_col < rlt_pkg::LcMax) begin
      lx_col = lx_col + 24'd1;
    end
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_id_start(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
  endfunction

  function automatic void put_ident();
    logic [31:0] len;
    rlt_pkg::tok_kind_t k;
    len = span();
    k = rlt_pkg::K_IDENT;
    if (lx_lone && len == 32'd1) k = rlt_pkg::K_WILD;
    else if (lx_not_prog == 3 && len == 32'd3) k = rlt_pkg::K_NOT;
    put_simple(k, len);
  endfunction

  function automatic void dot_failed();
    logic [23:0] col;
    col = lx_col;
    if (col < rlt_pkg::LcMax) col = (col > lx_kw_idx) ? col - 24'(lx_kw_idx) : 24'd1;
    put_token(rlt_pkg::K_DOT, lx_start, 32'd1, 64'd0, col, 8'd0);
    if (lx_kw_idx > 0) begin
      lx_start = lx_start + 32'd1;
      lx_not_prog = 0;
      lx_lone = 1'b0;
      lx_mode = rlt_pkg::M_IDENT;
    end else begin
      lx_mode = rlt_pkg::M_IDLE;
    end
  endfunction

  function automatic void start_token(logic [7:0] b);
    if (b == " " || b == 8'h09 || b == 8'h0d || b == 8'h0a) begin
      advance(b);
      return;
    end
    if (b == "%") begin
      advance(b);
      lx_mode = rlt_pkg::M_COMMENT;
      return;
    end
    lx_start = lx_pos;
    advance(b);
    case (b)
      ".": begin
        lx_kw_idx = 0;
        lx_cand = 3;
        lx_mode = rlt_pkg::M_DOT;
      end
      ",": put_simple(rlt_pkg::K_COMMA, 32'd1);
      "(": put_simple(rlt_pkg::K_LPAREN, 32'd1);
      ")": put_simple(rlt_pkg::K_RPAREN, 32'd1);
      "=": put_simple(rlt_pkg::K_EQ, 32'd1);
      ":": lx_mode = rlt_pkg::M_COLON;
      "!": lx_mode = rlt_pkg::M_BANG;
      "<": lx_mode = rlt_pkg::M_LT;
      ">": lx_mode = rlt_pkg::M_GT;
      "\"": lx_mode = rlt_pkg::M_STRING;
      default: begin
        if (is_digit(b)) begin
          lx_acc = 64'(b - "0");
          lx_mode = rlt_pkg::M_NUMBER;
        end else if (is_id_start(b)) begin
          lx_not_prog = (b == "n") ? 1 : 0;
          lx_lone = (b == "_");
          lx_mode = rlt_pkg::M_IDENT;
        end else begin
          put_simple(rlt_pkg::K_INVALID, 32'd1);
        end
      end
    endcase
  endfunction

  function automatic bit lex_byte(logic [7:0] b);
    string kw;
    string word_not;
    int unsigned klen;
    logic [31:0] len;
    word_not = "not";
    case (lx_mode)
      rlt_pkg::M_COMMENT: begin
        if (b == 8'h0a) begin
          lx_mode = rlt_pkg::M_IDLE;
          return 1'b0;
        end
        advance(b);
        return 1'b1;
      end
      rlt_pkg::M_NUMBER: begin
        if (is_digit(b)) begin
          lx_acc = lx_acc * 64'd10 + 64'(b - "0");
          advance(b);
          return 1'b1;
        end
        put_token(rlt_pkg::K_INT, lx_start, span(), lx_acc, lx_col, 8'd0);
        lx_mode = rlt_pkg::M_IDLE;
        return 1'b0;
      end
      rlt_pkg::M_IDENT: begin
        if (is_id_start(b) || is_digit(b)) begin
          len = span();
          if (len < 3 && lx_not_prog == len && b == word_not[len]) lx_not_prog++;
          lx_lone = 1'b0;
          advance(b);
          return 1'b1;
        end
        put_ident();
        lx_mode = rlt_pkg::M_IDLE;
        return 1'b0;
      end
      rlt_pkg::M_STRING: begin
        advance(b);
        if (b == "\"") begin
          put_simple(rlt_pkg::K_STRING, span());
          lx_mode = rlt_pkg::M_IDLE;
        end else if (b == "\\") begin
          lx_mode = rlt_pkg::M_ESC;
        end else begin
          put_token(rlt_pkg::K_CHAR, lx_start, 32'd0, 64'd0, lx_col, b);
        end
        return 1'b1;
      end
      rlt_pkg::M_ESC: begin
        advance(b);
        put_token(rlt_pkg::K_CHAR, lx_start, 32'd0, 64'd0, lx_col,
                  b == "n" ? 8'd10 : (b == "t" ? 8'd9 : b));
        lx_mode = rlt_pkg::M_STRING;
        return 1'b1;
      end
      rlt_pkg::M_DOT: begin
        if (lx_cand == 3) begin
          if (b == "p") lx_cand = 1;
          else if (b == "c") lx_cand = 2;
          else begin
            dot_failed();
            return 1'b0;
          end
        end
        if (lx_cand == 1) kw = "pred";
        else kw = {"clear", "_derived"};
        klen = kw.len();
        if (lx_kw_idx >= klen || b != kw[lx_kw_idx]) begin
          dot_failed();
          return 1'b0;
        end
        advance(b);
        lx_kw_idx++;
        if (lx_kw_idx == klen) begin
          put_simple(lx_cand == 1 ? rlt_pkg::K_PRED : rlt_pkg::K_CLEAR, 32'(klen + 1));
          lx_mode = rlt_pkg::M_IDLE;
        end
        return 1'b1;
      end
      rlt_pkg::M_COLON: begin
        lx_mode = rlt_pkg::M_IDLE;
        if (b == "-") begin
          advance(b);
          put_simple(rlt_pkg::K_ARROW, 32'd2);
          return 1'b1;
        end
        put_simple(rlt_pkg::K_COLON, 32'd1);
        return 1'b0;
      end
      rlt_pkg::M_BANG: begin
        lx_mode = rlt_pkg::M_IDLE;
        if (b == "=") begin
          advance(b);
          put_simple(rlt_pkg::K_NE, 32'd2);
          return 1'b1;
        end
        put_simple(rlt_pkg::K_INVALID, 32'd1);
        return 1'b0;
      end
      rlt_pkg::M_LT: begin
        lx_mode = rlt_pkg::M_IDLE;
        if (b == "=" || b == ">") begin
          advance(b);
          put_simple(b == "=" ? rlt_pkg::K_LE : rlt_pkg::K_NE, 32'd2);
          return 1'b1;
        end
        put_simple(rlt_pkg::K_LT, 32'd1);
        return 1'b0;
      end
      rlt_pkg::M_GT: begin
        lx_mode = rlt_pkg::M_IDLE;
        if (b == "=") begin
          advance(b);
          put_simple(rlt_pkg::K_GE, 32'd2);
          return 1'b1;
        end
        put_simple(rlt_pkg::K_GT, 32'd1);
        return 1'b0;
      end
      default: begin
        lx_mode = rlt_pkg::M_IDLE;
        start_token(b);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void lex_end();
    case (lx_mode)
      rlt_pkg::M_NUMBER: put_token(rlt_pkg::K_INT, lx_start, span(), lx_acc, lx_col, 8'd0);
      rlt_pkg::M_IDENT: put_ident();
      rlt_pkg::M_STRING, rlt_pkg::M_ESC: put_simple(rlt_pkg::K_INVALID, span());
      rlt_pkg::M_DOT: begin
        dot_failed();
        if (lx_mode == rlt_pkg::M_IDENT) put_ident();
      end
      rlt_pkg::M_COLON: put_simple(rlt_pkg::K_COLON, 32'd1);
      rlt_pkg::M_BANG: put_simple(rlt_pkg::K_INVALID, 32'd1);
      rlt_pkg::M_LT: put_simple(rlt_pkg::K_LT, 32'd1);
      rlt_pkg::M_GT: put_simple(rlt_pkg::K_GT, 32'd1);
      default: ;
    endcase
    put_token(rlt_pkg::K_EOF, lx_pos, 32'd0, 64'd0, lx_col, 8'd0);
  endfunction

  function automatic void predict_tokens(rlt_pkg::in_item_t it);
    rlt_pkg::out_item_t t;
    step_tokens.delete();
    if (it.kind) begin
      lex_end();
      lex_reset();
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (lex_byte(it.data_byte)) break;
      end
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) begin
      t = step_tokens[i];
      token_q.push_back(t);
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_token(rlt_pkg::out_item_t got);
    rlt_pkg::out_item_t want;
    if (token_q.size() == 0) begin
      report_mismatch("unexpected transaction, kind", 64'(got.token_kind), 64'd0);
      return;
    end
    want = token_q.pop_front();
    if (got.token_kind != want.token_kind)
      report_mismatch("token_kind", 64'(got.token_kind), 64'(want.token_kind));
    if (got.start_offset != want.start_offset)
      report_mismatch("start_offset", 64'(got.start_offset), 64'(want.start_offset));
    if (got.token_length != want.token_length)
      report_mismatch("token_length", 64'(got.token_length), 64'(want.token_length));
    if (got.number_value != want.number_value)
      report_mismatch("number_value", got.number_value, want.number_value);
    if (got.line_number != want.line_number)
      report_mismatch("line_number", 64'(got.line_number), 64'(want.line_number));
    if (got.column_number != want.column_number)
      report_mismatch("column_number", 64'(got.column_number), 64'(want.column_number));
    if (got.char_value != want.char_value)
      report_mismatch("char_value", 64'(got.char_value), 64'(want.char_value));
    if (got.last != want.last)
      report_mismatch("last", 64'(got.last), 64'(want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_token(out_data);
        rx_wait = quiet ? 0 : $urandom_range(0, 14);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(logic kind, logic [7:0] b);
    rlt_pkg::in_item_t it;
    int gap;
    it.kind = kind;
    it.data_byte = b;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic test_directed();
    send_text("not _ ab:-.pred");
    send_item(1'b1, 8'h00);
    send_text({".clear", "_derived"});
    send_item(1'b1, 8'hff);
    send_text("<>!=<=>=<>=,()!x %c\n\"\\n\\t\\\\\\\"\"");
    send_text("18446744073709551617 .cl .x\"ab\\");
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'h00);
  endtask

  task automatic test_pressure();
    rx_hold = 300;
    send_text("\"abcdefghijklmnopqrstuvwxyz\" 1,2,3");
    send_item(1'b1, 8'h00);
  endtask

  task automatic send_fragment();
    string frags[$];
    int r;
    frags = '{"not", "no", "nott", "_", "_a", "x1", "42", "007", ".pred", ".predx",
              {".clear", "_derived"}, ".clea", ".p", ".", ":-", ":", "!=", "!", "<>",
              "<=", "<", ">=", ">", "=", ",", "(", ")", "\"hi\\n\"", "\"a\\tb\\\\\"",
              "\"q\\\"\"", "%note\n", " ", "\t", "\r\n", "\n"};
    r = $urandom_range(0, 99);
    if (r < 10) send_item(1'b0, 8'($urandom_range(0, 255)));
    else if (r < 13) send_item(1'b1, 8'($urandom_range(0, 255)));
    else if (r < 18) send_text("99999999999999999999");
    else send_text(frags[$urandom_range(0, frags.size() - 1)]);
  endtask

  task automatic test_random(int n_frags, bit no_gaps);
    quiet = no_gaps;
    repeat (n_frags) send_fragment();
    quiet = 1'b0;
  endtask

  initial begin
    errors = 0;
    quiet = 1'b0;
    rx_hold = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    lex_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pressure();
    test_random(12, 1'b0);
    test_random(6, 1'b1);
    test_random(8, 1'b0);
    send_item(1'b1, 8'h00);
    in_valid <= 1'b0;
    while (token_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
